// ===== hw/rtl/fcu_pkg.sv =====
// Shared types, constants and helper functions of the fly camera update core.
package fcu_pkg;

  localparam int unsigned CordicStages = 16;

  localparam logic [15:0] FovReset = 16'd11520;
  localparam logic signed [35:0] PitchLimit = 36'sd5832704;
  localparam logic signed [35:0] HalfTurn = 36'sd11796480;
  localparam logic signed [35:0] FullTurn = 36'sd23592960;
  localparam logic signed [25:0] QuarterTurn = 26'sd5898240;
  localparam logic signed [25:0] HalfTurnAng = 26'sd11796480;
  localparam logic signed [32:0] CordicK = 33'sd652032874;
  localparam logic signed [65:0] UnitQ14 = 66'sd16384;
  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam logic [2:0] RegSensitivity = 3'd0;
  localparam logic [2:0] RegMinFov = 3'd1;
  localparam logic [2:0] RegMaxFov = 3'd2;
  localparam logic [2:0] RegUpX = 3'd3;
  localparam logic [2:0] RegUpY = 3'd4;
  localparam logic [2:0] RegUpZ = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_PITCH,
    ST_WRAP,
    ST_YAW_SET,
    ST_COR_INIT,
    ST_COR_ITER,
    ST_COR_FIN,
    ST_FWD,
    ST_CROSS,
    ST_SQ,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV_ITER,
    ST_DIV_FIN,
    ST_MOVE,
    ST_MOVE_CHK,
    ST_POS,
    ST_FOV,
    ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_YAW_SUM,
    OP_PITCH,
    OP_WRAP,
    OP_YAW_SET,
    OP_COR_INIT,
    OP_COR_ITER,
    OP_COR_FIN,
    OP_FWD_X,
    OP_FWD_Z,
    OP_CROSS,
    OP_SQ_ACC,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_FIN,
    OP_MOVE,
    OP_POS,
    OP_TARGET,
    OP_FOV,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    M_NONE,
    M_DXS,
    M_DYS,
    M_CPCY,
    M_CPSY,
    M_CROSS,
    M_SQ,
    M_MDT,
    M_EASE
  } msel_e;

  typedef struct packed {
    op_e         op;
    msel_e       msel;
    logic [2:0]  ma;
    logic [2:0]  oa;
    logic [4:0]  step;
    logic        pass;
  } cmd_t;

  typedef struct packed {
    logic mv_zero;
  } stat_t;

  typedef struct packed {
    logic [15:0]        sensitivity;
    logic [15:0]        min_fov;
    logic [15:0]        max_fov;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } cfg_t;

  function automatic logic [21:0] atan_deg(input logic [3:0] i);
    logic [21:0] r;
    unique case (i)
      4'd0:  r = 22'd2949120;
      4'd1:  r = 22'd1740967;
      4'd2:  r = 22'd919879;
      4'd3:  r = 22'd466945;
      4'd4:  r = 22'd234379;
      4'd5:  r = 22'd117304;
      4'd6:  r = 22'd58666;
      4'd7:  r = 22'd29335;
      4'd8:  r = 22'd14668;
      4'd9:  r = 22'd7334;
      4'd10: r = 22'd3667;
      4'd11: r = 22'd1833;
      4'd12: r = 22'd917;
      4'd13: r = 22'd458;
      4'd14: r = 22'd229;
      4'd15: r = 22'd115;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // Round half away from zero while shifting right.
  function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                    input logic [4:0] s);
    logic signed [65:0] half;
    logic signed [65:0] r;
    half = 66'sd1 <<< (s - 5'd1);
    if (!v[65]) begin
      r = (v + half) >>> s;
    end else begin
      r = -((-v + half) >>> s);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [65:0] v);
    logic signed [15:0] r;
    if (v > UnitQ14) begin
      r = 16'sd16384;
    end else if (v < -UnitQ14) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fly_camera_update_core.sv =====
// Top level of the fly camera update core: register port, sequencer and datapath.
// A frame request is accepted only while the core is idle; its result is presented
// at the end of the frame, and when the pressed keys give no movement the second
// normalization and the position update are skipped. The next request can be
// accepted once the result is presented. The one-stage-per-cycle CORDIC serves yaw
// and pitch; the bit-per-cycle square root and divider are shared by both vector
// normalizations. A finished frame waits only while the previous result is still
// held unaccepted in the result register.
module fly_camera_update_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] mouse_dx_i,
  input  logic signed [15:0] mouse_dy_i,
  input  logic [5:0]         key_mask_i,
  input  logic signed [7:0]  wheel_notches_i,
  input  logic [15:0]        frame_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] forward_x_o,
  output logic signed [15:0] forward_y_o,
  output logic signed [15:0] forward_z_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [15:0]        fov_out_o
);

  fcu_pkg::cfg_t  cfg_q;
  fcu_pkg::cmd_t  cmd;
  fcu_pkg::stat_t stat;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensitivity <= 16'd6554;
      cfg_q.min_fov     <= 16'd256;
      cfg_q.max_fov     <= 16'd23040;
      cfg_q.up_x        <= 16'sd0;
      cfg_q.up_y        <= 16'sd16384;
      cfg_q.up_z        <= 16'sd0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        fcu_pkg::RegSensitivity: cfg_q.sensitivity <= pwdata[15:0];
        fcu_pkg::RegMinFov:      cfg_q.min_fov     <= pwdata[15:0];
        fcu_pkg::RegMaxFov:      cfg_q.max_fov     <= pwdata[15:0];
        fcu_pkg::RegUpX:         cfg_q.up_x        <= pwdata[15:0];
        fcu_pkg::RegUpY:         cfg_q.up_y        <= pwdata[15:0];
        fcu_pkg::RegUpZ:         cfg_q.up_z        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      fcu_pkg::RegSensitivity: prdata = {16'd0, cfg_q.sensitivity};
      fcu_pkg::RegMinFov:      prdata = {16'd0, cfg_q.min_fov};
      fcu_pkg::RegMaxFov:      prdata = {16'd0, cfg_q.max_fov};
      fcu_pkg::RegUpX:         prdata = 32'(cfg_q.up_x);
      fcu_pkg::RegUpY:         prdata = 32'(cfg_q.up_y);
      fcu_pkg::RegUpZ:         prdata = 32'(cfg_q.up_z);
      default:                 prdata = '0;
    endcase
  end

  fcu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fcu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_i           (cfg_q),
    .mouse_dx_i      (mouse_dx_i),
    .mouse_dy_i      (mouse_dy_i),
    .key_mask_i      (key_mask_i),
    .wheel_notches_i (wheel_notches_i),
    .frame_time_i    (frame_time_i),
    .forward_x_o     (forward_x_o),
    .forward_y_o     (forward_y_o),
    .forward_z_o     (forward_z_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_o         (pos_z_o),
    .fov_out_o       (fov_out_o)
  );

endmodule

// ===== hw/rtl/fcu_ctrl.sv =====
// Sequencer of the fly camera update core: walks the datapath through one frame.
module fcu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  fcu_pkg::stat_t stat_i,
  output fcu_pkg::cmd_t  cmd_o
);

  fcu_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic       pass_q, pass_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcu_pkg::ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    comp_d      = comp_q;
    pass_d      = pass_q;
    cmd_o.op    = fcu_pkg::OP_NONE;
    cmd_o.msel  = fcu_pkg::M_NONE;
    cmd_o.ma    = cnt_q[2:0];
    cmd_o.oa    = 3'(cnt_q[2:0] - 3'd1);
    cmd_o.step  = cnt_q;
    cmd_o.pass  = pass_q;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      fcu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = fcu_pkg::OP_LOAD;
          state_d  = fcu_pkg::ST_MUL_DX;
        end
      end
      fcu_pkg::ST_MUL_DX: begin
        cmd_o.msel = fcu_pkg::M_DXS;
        state_d    = fcu_pkg::ST_MUL_DY;
      end
      fcu_pkg::ST_MUL_DY: begin
        cmd_o.msel = fcu_pkg::M_DYS;
        cmd_o.op   = fcu_pkg::OP_YAW_SUM;
        state_d    = fcu_pkg::ST_PITCH;
      end
      fcu_pkg::ST_PITCH: begin
        cmd_o.op = fcu_pkg::OP_PITCH;
        cnt_d    = 5'd7;
        state_d  = fcu_pkg::ST_WRAP;
      end
      fcu_pkg::ST_WRAP: begin
        cmd_o.op = fcu_pkg::OP_WRAP;
        if (cnt_q == 5'd0) begin
          state_d = fcu_pkg::ST_YAW_SET;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      fcu_pkg::ST_YAW_SET: begin
        cmd_o.op = fcu_pkg::OP_YAW_SET;
        pass_d   = 1'b0;
        state_d  = fcu_pkg::ST_COR_INIT;
      end
      fcu_pkg::ST_COR_INIT: begin
        cmd_o.op = fcu_pkg::OP_COR_INIT;
        cnt_d    = '0;
        state_d  = fcu_pkg::ST_COR_ITER;
      end
      fcu_pkg::ST_COR_ITER: begin
        cmd_o.op = fcu_pkg::OP_COR_ITER;
        if (cnt_q == 5'(fcu_pkg::CordicStages - 1)) begin
          state_d = fcu_pkg::ST_COR_FIN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      fcu_pkg::ST_COR_FIN: begin
        cmd_o.op = fcu_pkg::OP_COR_FIN;
        cnt_d    = '0;
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = fcu_pkg::ST_COR_INIT;
        end else begin
          state_d = fcu_pkg::ST_FWD;
        end
      end
      fcu_pkg::ST_FWD: begin
        priority case (cnt_q)
          5'd0: cmd_o.msel = fcu_pkg::M_CPCY;
          5'd1: begin
            cmd_o.msel = fcu_pkg::M_CPSY;
            cmd_o.op   = fcu_pkg::OP_FWD_X;
          end
          default: cmd_o.op = fcu_pkg::OP_FWD_Z;
        endcase
        if (cnt_q == 5'd2) begin
          cnt_d   = '0;
          state_d = fcu_pkg::ST_CROSS;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      fcu_pkg::ST_CROSS: begin
        if (cnt_q < 5'd6) begin
          cmd_o.msel = fcu_pkg::M_CROSS;
        end
        if (cnt_q != 5'd0) begin
          cmd_o.op = fcu_pkg::OP_CROSS;
        end
        if (cnt_q == 5'd6) begin
          cnt_d   = '0;
          pass_d  = 1'b0;
          state_d = fcu_pkg::ST_SQ;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      fcu_pkg::ST_SQ: begin
        if (cnt_q < 5'd3) begin
          cmd_o.msel = fcu_pkg::M_SQ;
        end
        if (cnt_q != 5'd0) begin
          cmd_o.op = fcu_pkg::OP_SQ_ACC;
        end
        if (cnt_q == 5'd3) begin
          cnt_d   = '0;
          state_d = fcu_pkg::ST_SQRT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      fcu_pkg::ST_SQRT: begin
        cmd_o.op = fcu_pkg::OP_SQRT_STEP;
        if (cnt_q == 5'd31) begin
          comp_d  = '0;
          state_d = fcu_pkg::ST_DIV_INIT;
        end
        cnt_d = cnt_q + 5'd1;
      end
      fcu_pkg::ST_DIV_INIT: begin
        cmd_o.op = fcu_pkg::OP_DIV_INIT;
        cmd_o.oa = {1'b0, comp_q};
        cnt_d    = '0;
        state_d  = fcu_pkg::ST_DIV_ITER;
      end
      fcu_pkg::ST_DIV_ITER: begin
        cmd_o.op   = fcu_pkg::OP_DIV_STEP;
        cmd_o.step = 5'd15 - cnt_q;
        if (cnt_q == 5'd15) begin
          state_d = fcu_pkg::ST_DIV_FIN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      fcu_pkg::ST_DIV_FIN: begin
        cmd_o.op = fcu_pkg::OP_DIV_FIN;
        cmd_o.oa = {1'b0, comp_q};
        cnt_d    = '0;
        if (comp_q == 2'd2) begin
          state_d = pass_q ? fcu_pkg::ST_POS : fcu_pkg::ST_MOVE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = fcu_pkg::ST_DIV_INIT;
        end
      end
      fcu_pkg::ST_MOVE: begin
        cmd_o.op = fcu_pkg::OP_MOVE;
        state_d  = fcu_pkg::ST_MOVE_CHK;
      end
      fcu_pkg::ST_MOVE_CHK: begin
        cnt_d = '0;
        if (stat_i.mv_zero) begin
          state_d = fcu_pkg::ST_FOV;
        end else begin
          pass_d  = 1'b1;
          state_d = fcu_pkg::ST_SQ;
        end
      end
      fcu_pkg::ST_POS: begin
        if (cnt_q < 5'd3) begin
          cmd_o.msel = fcu_pkg::M_MDT;
        end
        if (cnt_q != 5'd0) begin
          cmd_o.op = fcu_pkg::OP_POS;
        end
        if (cnt_q == 5'd3) begin
          cnt_d   = '0;
          state_d = fcu_pkg::ST_FOV;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      fcu_pkg::ST_FOV: begin
        priority case (cnt_q)
          5'd0: cmd_o.op = fcu_pkg::OP_TARGET;
          5'd1: cmd_o.msel = fcu_pkg::M_EASE;
          default: cmd_o.op = fcu_pkg::OP_FOV;
        endcase
        if (cnt_q == 5'd2) begin
          cnt_d   = '0;
          state_d = fcu_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      fcu_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = fcu_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = fcu_pkg::ST_IDLE;
        end
      end
      default: state_d = fcu_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/fcu_dp.sv =====
// Datapath of the fly camera update core: shared multiplier, CORDIC, root and divider.
module fcu_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcu_pkg::cmd_t       cmd_i,
  output fcu_pkg::stat_t      stat_o,
  input  fcu_pkg::cfg_t       cfg_i,
  input  logic signed [15:0]  mouse_dx_i,
  input  logic signed [15:0]  mouse_dy_i,
  input  logic [5:0]          key_mask_i,
  input  logic signed [7:0]   wheel_notches_i,
  input  logic [15:0]         frame_time_i,
  output logic signed [15:0]  forward_x_o,
  output logic signed [15:0]  forward_y_o,
  output logic signed [15:0]  forward_z_o,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic [15:0]         fov_out_o
);

  // frame request
  logic signed [15:0] dx_q, dy_q;
  logic [5:0]         keys_q;
  logic signed [7:0]  notch_q;
  logic [15:0]        dt_q;

  // persistent camera state
  logic signed [24:0] yaw_q;
  logic signed [23:0] pitch_q;
  logic signed [31:0] pos_q [3];
  logic [15:0]        target_q, fov_q;

  // working registers
  logic signed [65:0] prod_q;
  logic signed [35:0] v_q;
  logic signed [32:0] cx_q, cy_q;
  logic signed [25:0] cz_q;
  logic               flip_q;
  logic signed [15:0] syaw_q, cyaw_q, spit_q, cpit_q;
  logic signed [15:0] fwd_q [3];
  logic signed [31:0] tmp_q;
  logic signed [31:0] cr_q [3];
  logic [63:0]        sum_q, root_q;
  logic [47:0]        rem_q;
  logic [15:0]        quo_q;
  logic               neg_q;
  logic signed [15:0] nrm_q [3];
  logic signed [18:0] mv_q [3];

  // result holding registers
  logic signed [15:0] ofwd_q [3];
  logic signed [31:0] opos_q [3];
  logic [15:0]        ofov_q;

  logic signed [32:0] ma_s, mb_s;
  logic signed [65:0] prod_d;
  logic signed [31:0] nv [3];
  logic signed [15:0] up_v [3];
  logic signed [15:0] flat_v [3];
  logic [20:0]        w10;
  logic [16:0]        wv;

  assign up_v[0] = cfg_i.up_x;
  assign up_v[1] = cfg_i.up_y;
  assign up_v[2] = cfg_i.up_z;
  assign flat_v[0] = cyaw_q;
  assign flat_v[1] = 16'sd0;
  assign flat_v[2] = syaw_q;

  assign w10 = 21'(dt_q) * 21'd10;
  assign wv  = (w10 > 21'(fcu_pkg::OneQ16)) ? fcu_pkg::OneQ16 : w10[16:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = cmd_i.pass ? 32'(mv_q[i]) : cr_q[i];
    end
  end

  // operand select
  always_comb begin
    ma_s = '0;
    mb_s = '0;
    unique case (cmd_i.msel)
      fcu_pkg::M_NONE: begin
        ma_s = '0;
        mb_s = '0;
      end
      fcu_pkg::M_DXS: begin
        ma_s = 33'(dx_q);
        mb_s = $signed({17'd0, cfg_i.sensitivity});
      end
      fcu_pkg::M_DYS: begin
        ma_s = 33'(dy_q);
        mb_s = $signed({17'd0, cfg_i.sensitivity});
      end
      fcu_pkg::M_CPCY: begin
        ma_s = 33'(cpit_q);
        mb_s = 33'(cyaw_q);
      end
      fcu_pkg::M_CPSY: begin
        ma_s = 33'(cpit_q);
        mb_s = 33'(syaw_q);
      end
      fcu_pkg::M_CROSS: begin
        priority case (cmd_i.ma)
          3'd0: begin ma_s = 33'(fwd_q[1]); mb_s = 33'(cfg_i.up_z); end
          3'd1: begin ma_s = 33'(fwd_q[2]); mb_s = 33'(cfg_i.up_y); end
          3'd2: begin ma_s = 33'(fwd_q[2]); mb_s = 33'(cfg_i.up_x); end
          3'd3: begin ma_s = 33'(fwd_q[0]); mb_s = 33'(cfg_i.up_z); end
          3'd4: begin ma_s = 33'(fwd_q[0]); mb_s = 33'(cfg_i.up_y); end
          default: begin ma_s = 33'(fwd_q[1]); mb_s = 33'(cfg_i.up_x); end
        endcase
      end
      fcu_pkg::M_SQ: begin
        ma_s = 33'(nv[cmd_i.ma[1:0]]);
        mb_s = 33'(nv[cmd_i.ma[1:0]]);
      end
      fcu_pkg::M_MDT: begin
        ma_s = 33'(nrm_q[cmd_i.ma[1:0]]);
        mb_s = $signed({17'd0, dt_q});
      end
      fcu_pkg::M_EASE: begin
        ma_s = $signed({17'd0, target_q}) - $signed({17'd0, fov_q});
        mb_s = $signed({16'd0, wv});
      end
      default: begin
        ma_s = '0;
        mb_s = '0;
      end
    endcase
  end

  assign prod_d = ma_s * mb_s;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // next values of the working arithmetic
  logic signed [35:0] ysum, ywrap, psum, ft;
  logic signed [25:0] ang, zf, atn;
  logic               flip_d;
  logic signed [32:0] xs, ys;
  logic signed [15:0] xr, yr;
  logic signed [65:0] r14;
  logic [63:0]        bit_v, trial;
  logic [31:0]        ac;
  logic [47:0]        dv;
  logic [15:0]        qc;
  logic signed [18:0] mv_d [3];
  logic signed [65:0] t3, dpos;
  logic signed [33:0] psat [3];
  logic signed [19:0] nn, tgt;
  logic signed [65:0] ease;

  always_comb begin
    ysum = 36'(yaw_q) + $signed(prod_q[35:0]) + fcu_pkg::HalfTurn;
    ywrap = ysum[35] ? ysum + (fcu_pkg::FullTurn <<< 7) : ysum;
    psum = 36'(pitch_q) - $signed(prod_q[35:0]);
    ft = fcu_pkg::FullTurn <<< cmd_i.step[2:0];

    ang = cmd_i.pass ? 26'(pitch_q) : 26'(yaw_q);
    flip_d = 1'b0;
    zf = ang;
    if (ang > fcu_pkg::QuarterTurn) begin
      zf = ang - fcu_pkg::HalfTurnAng;
      flip_d = 1'b1;
    end else if (ang < -fcu_pkg::QuarterTurn) begin
      zf = ang + fcu_pkg::HalfTurnAng;
      flip_d = 1'b1;
    end
    atn = $signed({4'd0, fcu_pkg::atan_deg(cmd_i.step[3:0])});
    xs = cx_q >>> cmd_i.step[3:0];
    ys = cy_q >>> cmd_i.step[3:0];
    xr = fcu_pkg::clamp_unit(fcu_pkg::round_shift(66'(cx_q), 5'd16));
    yr = fcu_pkg::clamp_unit(fcu_pkg::round_shift(66'(cy_q), 5'd16));
    r14 = fcu_pkg::round_shift(prod_q, 5'd14);

    bit_v = 64'd1 << (6'd62 - {cmd_i.step, 1'b0});
    trial = root_q + bit_v;
    ac = nv[cmd_i.oa[1:0]][31] ? 32'(-nv[cmd_i.oa[1:0]]) : 32'(nv[cmd_i.oa[1:0]]);
    dv = 48'(root_q[31:0]) << cmd_i.step[3:0];
    qc = (quo_q > 16'd16384) ? 16'd16384 : quo_q;

    for (int i = 0; i < 3; i++) begin
      mv_d[i] = '0;
      if (keys_q[0]) mv_d[i] = mv_d[i] + 19'(flat_v[i]);
      if (keys_q[1]) mv_d[i] = mv_d[i] - 19'(flat_v[i]);
      if (keys_q[2]) mv_d[i] = mv_d[i] + 19'(nrm_q[i]);
      if (keys_q[3]) mv_d[i] = mv_d[i] - 19'(nrm_q[i]);
      if (keys_q[4]) mv_d[i] = mv_d[i] + 19'(up_v[i]);
      if (keys_q[5]) mv_d[i] = mv_d[i] - 19'(up_v[i]);
    end

    t3 = prod_q + (prod_q <<< 1);
    dpos = fcu_pkg::round_shift(t3, 5'd15);
    for (int i = 0; i < 3; i++) begin
      psat[i] = 34'(pos_q[i]) + $signed(dpos[33:0]);
    end

    nn = 20'(notch_q);
    tgt = $signed({4'd0, target_q}) - ((nn <<< 10) + (nn <<< 8));
    if (tgt < $signed({4'd0, cfg_i.min_fov})) tgt = $signed({4'd0, cfg_i.min_fov});
    if (tgt > $signed({4'd0, cfg_i.max_fov})) tgt = $signed({4'd0, cfg_i.max_fov});
    ease = fcu_pkg::round_shift(prod_q, 5'd16);
  end

  // camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q    <= '0;
      pitch_q  <= '0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      target_q <= fcu_pkg::FovReset;
      fov_q    <= fcu_pkg::FovReset;
    end else begin
      unique case (cmd_i.op)
        fcu_pkg::OP_PITCH: begin
          if (psum > fcu_pkg::PitchLimit) begin
            pitch_q <= 24'(fcu_pkg::PitchLimit);
          end else if (psum < -fcu_pkg::PitchLimit) begin
            pitch_q <= 24'(-fcu_pkg::PitchLimit);
          end else begin
            pitch_q <= psum[23:0];
          end
        end
        fcu_pkg::OP_YAW_SET: yaw_q <= 25'(v_q - fcu_pkg::HalfTurn);
        fcu_pkg::OP_POS: begin
          if (psat[cmd_i.oa[1:0]] > 34'sh0_7FFF_FFFF) begin
            pos_q[cmd_i.oa[1:0]] <= 32'sh7FFF_FFFF;
          end else if (psat[cmd_i.oa[1:0]] < -34'sh0_8000_0000) begin
            pos_q[cmd_i.oa[1:0]] <= 32'sh8000_0000;
          end else begin
            pos_q[cmd_i.oa[1:0]] <= psat[cmd_i.oa[1:0]][31:0];
          end
        end
        fcu_pkg::OP_TARGET: target_q <= tgt[15:0];
        fcu_pkg::OP_FOV: fov_q <= 16'($signed({50'd0, fov_q}) + ease);
        default: ;
      endcase
    end
  end

  // working, request and result holding registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      fcu_pkg::OP_LOAD: begin
        dx_q    <= mouse_dx_i;
        dy_q    <= mouse_dy_i;
        keys_q  <= key_mask_i;
        notch_q <= wheel_notches_i;
        dt_q    <= frame_time_i;
      end
      fcu_pkg::OP_YAW_SUM: v_q <= ywrap;
      fcu_pkg::OP_WRAP: begin
        if (v_q >= ft) v_q <= v_q - ft;
      end
      fcu_pkg::OP_COR_INIT: begin
        cx_q   <= fcu_pkg::CordicK;
        cy_q   <= '0;
        cz_q   <= zf;
        flip_q <= flip_d;
      end
      fcu_pkg::OP_COR_ITER: begin
        if (!cz_q[25]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atn;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atn;
        end
      end
      fcu_pkg::OP_COR_FIN: begin
        if (cmd_i.pass) begin
          cpit_q <= flip_q ? -xr : xr;
          spit_q <= flip_q ? -yr : yr;
        end else begin
          cyaw_q <= flip_q ? -xr : xr;
          syaw_q <= flip_q ? -yr : yr;
        end
      end
      fcu_pkg::OP_FWD_X: begin
        fwd_q[0] <= r14[15:0];
        fwd_q[1] <= spit_q;
      end
      fcu_pkg::OP_FWD_Z: fwd_q[2] <= r14[15:0];
      fcu_pkg::OP_CROSS: begin
        if (!cmd_i.oa[0]) begin
          tmp_q <= prod_q[31:0];
        end else begin
          cr_q[cmd_i.oa[2:1]] <= tmp_q - prod_q[31:0];
        end
      end
      fcu_pkg::OP_SQ_ACC: begin
        root_q <= '0;
        if (cmd_i.oa == 3'd0) begin
          sum_q <= prod_q[63:0];
        end else begin
          sum_q <= sum_q + prod_q[63:0];
        end
      end
      fcu_pkg::OP_SQRT_STEP: begin
        if (sum_q >= trial) begin
          sum_q  <= sum_q - trial;
          root_q <= (root_q >> 1) + bit_v;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      fcu_pkg::OP_DIV_INIT: begin
        rem_q <= {2'd0, ac, 14'd0} + 48'(root_q[31:1]);
        quo_q <= '0;
        neg_q <= nv[cmd_i.oa[1:0]][31];
      end
      fcu_pkg::OP_DIV_STEP: begin
        if (rem_q >= dv) begin
          rem_q <= rem_q - dv;
          quo_q[cmd_i.step[3:0]] <= 1'b1;
        end
      end
      fcu_pkg::OP_DIV_FIN: begin
        if (root_q == 64'd0) begin
          nrm_q[cmd_i.oa[1:0]] <= '0;
        end else begin
          nrm_q[cmd_i.oa[1:0]] <= neg_q ? -$signed(qc) : $signed(qc);
        end
      end
      fcu_pkg::OP_MOVE: begin
        mv_q[0] <= mv_d[0];
        mv_q[1] <= mv_d[1];
        mv_q[2] <= mv_d[2];
      end
      fcu_pkg::OP_OUT: begin
        for (int i = 0; i < 3; i++) begin
          ofwd_q[i] <= fwd_q[i];
          opos_q[i] <= pos_q[i];
        end
        ofov_q <= fov_q;
      end
      default: ;
    endcase
  end

  assign stat_o.mv_zero = (mv_q[0] == '0) && (mv_q[1] == '0) && (mv_q[2] == '0);

  assign forward_x_o = ofwd_q[0];
  assign forward_y_o = ofwd_q[1];
  assign forward_z_o = ofwd_q[2];
  assign pos_x_o     = opos_q[0];
  assign pos_y_o     = opos_q[1];
  assign pos_z_o     = opos_q[2];
  assign fov_out_o   = ofov_q;

endmodule

// ===== hw/rtl/fcu_chk.sv =====
// Port-level checks of the fly camera update core, bound to the top level.
module fcu_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] forward_x_o,
  input logic signed [15:0] forward_y_o,
  input logic signed [31:0] pos_x_o,
  input logic [15:0]        fov_out_o
);

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while a frame was in flight");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared in the cycle after a request");

  a_fwd_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> forward_x_o <= 16'sd16384 && forward_x_o >= -16'sd16384
                 && forward_y_o <= 16'sd16384 && forward_y_o >= -16'sd16384)
    else $error("view direction component beyond unit range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_x_o) && $stable(fov_out_o))
    else $error("stalled result changed");

endmodule

bind fly_camera_update_core fcu_chk u_fcu_chk (.*);

// ===== verif/fly_camera_update_core_tb.sv =====
// Testbench for fly_camera_update_core: directed and random frames checked against a camera predictor.
`timescale 1ns / 1ps

module fly_camera_update_core_tb;

  localparam int WatchdogLimit = 8000;
  localparam int SettleCycles = 250;
  localparam int PhaseItems = 290;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [5:0]         keys;
    logic signed [7:0]  notches;
    logic [15:0]        dt;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        fov;
  } view_t;

  class camera_scoreboard;
    fcu_pkg::cfg_t regs;
    longint yaw_q, pitch_q, target_q, fov_q;
    longint pos[3];
    longint last_fwd[3];
    view_t  pending[$];
    int     mismatches;

    function new();
      regs.sensitivity = 16'd6554;
      regs.min_fov = 16'd256;
      regs.max_fov = 16'd23040;
      regs.up_x = 16'sd0;
      regs.up_y = 16'sd16384;
      regs.up_z = 16'sd0;
      yaw_q = 0;
      pitch_q = 0;
      target_q = fcu_pkg::FovReset;
      fov_q = fcu_pkg::FovReset;
      foreach (pos[i]) pos[i] = 0;
      foreach (last_fwd[i]) last_fwd[i] = 0;
      mismatches = 0;
    endfunction

    function longint rnd_shift(longint v, int s);
      longint half;
      half = longint'(1) <<< (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -((-v + half) >>> s);
    endfunction

    function longint rnd_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
      longint x, y, z, nx;
      bit flip;
      x = fcu_pkg::CordicK;
      y = 0;
      z = ang;
      flip = 0;
      if (z > fcu_pkg::QuarterTurn) begin
        z -= fcu_pkg::HalfTurn;
        flip = 1;
      end else if (z < -fcu_pkg::QuarterTurn) begin
        z += fcu_pkg::HalfTurn;
        flip = 1;
      end
      for (int i = 0; i < fcu_pkg::CordicStages; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(fcu_pkg::atan_deg(4'(i)));
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(fcu_pkg::atan_deg(4'(i)));
        end
        x = nx;
      end
      x = clip(rnd_shift(x, 16), -16384, 16384);
      y = clip(rnd_shift(y, 16), -16384, 16384);
      c = flip ? -x : x;
      s = flip ? -y : y;
    endtask

    task automatic unit_vec(input longint v[3], output longint o[3]);
      longint unsigned acc;
      longint len;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += longint'(v[i] * v[i]);
      len = root(acc);
      for (int i = 0; i < 3; i++)
        o[i] = len == 0 ? 0 : clip(rnd_div(v[i] * 16384, len), -16384, 16384);
    endtask

    task automatic note_request(input frame_t f);
      longint up[3], fwd[3], flat[3], cr[3], rt[3], mv[3], m[3];
      longint sy, cy, sp, cp, w, sens;
      view_t e;
      sens = regs.sensitivity;
      up[0] = regs.up_x;
      up[1] = regs.up_y;
      up[2] = regs.up_z;
      yaw_q = (yaw_q + longint'(f.dx) * sens + fcu_pkg::HalfTurn) % fcu_pkg::FullTurn;
      if (yaw_q < 0) yaw_q += fcu_pkg::FullTurn;
      yaw_q -= fcu_pkg::HalfTurn;
      pitch_q = clip(pitch_q - longint'(f.dy) * sens, -fcu_pkg::PitchLimit,
                     fcu_pkg::PitchLimit);
      sin_cos(yaw_q, sy, cy);
      sin_cos(pitch_q, sp, cp);
      fwd[0] = rnd_shift(cp * cy, 14);
      fwd[1] = sp;
      fwd[2] = rnd_shift(cp * sy, 14);
      flat[0] = cy;
      flat[1] = 0;
      flat[2] = sy;
      cr[0] = fwd[1] * up[2] - fwd[2] * up[1];
      cr[1] = fwd[2] * up[0] - fwd[0] * up[2];
      cr[2] = fwd[0] * up[1] - fwd[1] * up[0];
      unit_vec(cr, rt);
      for (int i = 0; i < 3; i++) begin
        mv[i] = 0;
        if (f.keys[0]) mv[i] += flat[i];
        if (f.keys[1]) mv[i] -= flat[i];
        if (f.keys[2]) mv[i] += rt[i];
        if (f.keys[3]) mv[i] -= rt[i];
        if (f.keys[4]) mv[i] += up[i];
        if (f.keys[5]) mv[i] -= up[i];
      end
      if (mv[0] != 0 || mv[1] != 0 || mv[2] != 0) begin
        unit_vec(mv, m);
        for (int i = 0; i < 3; i++)
          pos[i] = clip(pos[i] + rnd_shift(m[i] * longint'(f.dt) * 3, 15),
                        -64'sd2147483648, 64'sd2147483647);
      end
      target_q -= longint'(f.notches) * 1280;
      if (target_q < longint'(regs.min_fov)) target_q = regs.min_fov;
      if (target_q > longint'(regs.max_fov)) target_q = regs.max_fov;
      w = 10 * longint'(f.dt);
      if (w > longint'(fcu_pkg::OneQ16)) w = fcu_pkg::OneQ16;
      fov_q = fov_q + rnd_shift((target_q - fov_q) * w, 16);
      foreach (fwd[i]) last_fwd[i] = fwd[i];
      e.fwd_x = 16'(fwd[0]);
      e.fwd_y = 16'(fwd[1]);
      e.fwd_z = 16'(fwd[2]);
      e.pos_x = 32'(pos[0]);
      e.pos_y = 32'(pos[1]);
      e.pos_z = 32'(pos[2]);
      e.fov = 16'(fov_q);
      pending.push_back(e);
    endtask

    function void check_result(view_t a);
      view_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result fov=%0d", a.fov);
        return;
      end
      e = pending.pop_front();
      if (a != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result differs: exp fwd %0d %0d %0d pos %0d %0d %0d fov %0d | got fwd %0d %0d %0d pos %0d %0d %0d fov %0d",
                   e.fwd_x, e.fwd_y, e.fwd_z, e.pos_x, e.pos_y, e.pos_z, e.fov,
                   a.fwd_x, a.fwd_y, a.fwd_z, a.pos_x, a.pos_y, a.pos_z, a.fov);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] mouse_dx_i = '0, mouse_dy_i = '0;
  logic [5:0]         key_mask_i = '0;
  logic signed [7:0]  wheel_notches_i = '0;
  logic [15:0]        frame_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] forward_x_o, forward_y_o, forward_z_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [15:0]        fov_out_o;

  camera_scoreboard sb = new();
  int tx_idle_pct = 16;
  int rx_stall_pct = 58;
  int quiet_cycles = 0;

  fly_camera_update_core u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    view_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.fwd_x = forward_x_o;
      r.fwd_y = forward_y_o;
      r.fwd_z = forward_z_o;
      r.pos_x = pos_x_o;
      r.pos_y = pos_y_o;
      r.pos_z = pos_z_o;
      r.fov = fov_out_o;
      sb.check_result(r);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("fly_camera_update_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {16'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      fcu_pkg::RegSensitivity: sb.regs.sensitivity = val;
      fcu_pkg::RegMinFov:      sb.regs.min_fov = val;
      fcu_pkg::RegMaxFov:      sb.regs.max_fov = val;
      fcu_pkg::RegUpX:         sb.regs.up_x = val;
      fcu_pkg::RegUpY:         sb.regs.up_y = val;
      default:                 sb.regs.up_z = val;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_frame(input frame_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    mouse_dx_i = f.dx;
    mouse_dy_i = f.dy;
    key_mask_i = f.keys;
    wheel_notches_i = f.notches;
    frame_time_i = f.dt;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(f);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send(input int dx, input int dy, input int keys, input int wn, input int dt);
    frame_t f;
    f.dx = 16'(dx);
    f.dy = 16'(dy);
    f.keys = 6'(keys);
    f.notches = 8'(wn);
    f.dt = 16'(dt);
    send_frame(f);
  endtask

  task automatic send_random();
    frame_t f;
    f.dx = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(400) - 200);
    f.dy = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(400) - 200);
    f.keys = 6'($urandom);
    f.notches = 8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(6) - 3);
    case ($urandom_range(7))
      0:       f.dt = 16'd0;
      1:       f.dt = 16'hFFFF;
      2, 3:    f.dt = 16'($urandom);
      default: f.dt = 16'($urandom_range(2000));
    endcase
    send_frame(f);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_all(input int sens, input int mn, input int mx,
                         input int ux, input int uy, input int uz);
    write_reg(fcu_pkg::RegSensitivity, 16'(sens));
    write_reg(fcu_pkg::RegMinFov, 16'(mn));
    write_reg(fcu_pkg::RegMaxFov, 16'(mx));
    write_reg(fcu_pkg::RegUpX, 16'(ux));
    write_reg(fcu_pkg::RegUpY, 16'(uy));
    write_reg(fcu_pkg::RegUpZ, 16'(uz));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(0, 0, 0, 0, 0);
    send(32767, 0, 6'b000001, 0, 65535);
    send(-32768, 0, 6'b000010, 127, 1000);
    send(0, -32768, 6'b000100, -128, 65535);
    send(0, 32767, 6'b001000, 0, 6553);
    send(0, 32767, 6'b010000, 1, 100);
    send(100, -100, 6'b100000, -1, 300);
    send(-100, 100, 6'b000011, 5, 500);
    send(50, 0, 6'b001100, 0, 700);
    send(0, 0, 6'b110000, 0, 700);
    send(0, 0, 6'b111111, -60, 6554);
    send(7, -7, 6'b010101, 60, 6553);
    send(0, 0, 6'b101010, 0, 0);
    send(-1, 1, 6'b000101, 0, 65535);
    for (int i = 0; i < PhaseItems; i++) send_random();
    drain();

    set_all(65535, 0, 45824, 0, 16384, 0);
    for (int i = 0; i < PhaseItems; i++) send_random();
    drain();

    tx_idle_pct = 58;
    rx_stall_pct = 16;
    write_reg(fcu_pkg::RegSensitivity, 16'd0);
    write_reg(fcu_pkg::RegMinFov, 16'd20000);
    write_reg(fcu_pkg::RegMaxFov, 16'd3000);
    write_reg(fcu_pkg::RegUpX, 16'(sb.last_fwd[0]));
    write_reg(fcu_pkg::RegUpY, 16'(sb.last_fwd[1]));
    write_reg(fcu_pkg::RegUpZ, 16'(sb.last_fwd[2]));
    for (int i = 0; i < PhaseItems; i++) send_random();
    drain();

    set_all(int'($urandom_range(20000)), 45824, 45824, 0, 0, 0);
    for (int i = 0; i < PhaseItems; i++) send_random();
    drain();

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_all(1, 0, 0, -32768, 32767, -16384);
    for (int i = 0; i < PhaseItems; i++) send_random();
    drain();

    set_all(6554, 256, 23040, int'($urandom), int'($urandom), int'($urandom));
    for (int i = 0; i < PhaseItems; i++) send_random();
    drain();

    if (sb.mismatches == 0) begin
      $display("fly_camera_update_core: match");
    end else begin
      $display("fly_camera_update_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fcu_pkg.sv
hw/rtl/fcu_ctrl.sv
hw/rtl/fcu_dp.sv
hw/rtl/fly_camera_update_core.sv
hw/rtl/fcu_chk.sv
verif/fly_camera_update_core_tb.sv
